// ===== sv/bounded_priority_event_queue_defines.svh =====
// Assertion macros used by the priority event queue datapath
`ifndef BOUNDED_PRIORITY_EVENT_QUEUE_DEFINES_SVH
`define BOUNDED_PRIORITY_EVENT_QUEUE_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define BPEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that must hold in the cycle after the trigger
`define BPEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bpeq_pkg.sv =====
// Types and constants for the bounded priority event queue
package bpeq_pkg;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned ENTRY_W  = PRIO_W + HANDLE_W;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned MAXE_W   = 7;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [CNT_W-1:0]  CNT_DEPTH   = CNT_W'(DEPTH);
  localparam logic [MAXE_W-1:0] MAXE_RESET  = MAXE_W'(64);

  // Register index, taken from paddr bit 2
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_MAX    = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 3'd0,
    OP_GET   = 3'd1,
    OP_CLEAN = 3'd2,
    OP_ABORT = 3'd3,
    OP_STOP  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_UNINIT  = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_ABORT   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_POP,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic decode;
    logic step;
    logic place;
    logic capture;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic put_ok;
    logic get_ok;
    logic shift_more;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/bpeq_ram.sv =====
// Generic single write port RAM with registered read
module bpeq_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bpeq_ctrl.sv =====
// Sequencer for the priority event queue
module bpeq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  bpeq_pkg::dp_stat_t stat,
  output bpeq_pkg::dp_cmd_t  cmd
);

  bpeq_pkg::state_t state;
  bpeq_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpeq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bpeq_pkg::S_IDLE: begin
        if (req_valid) state_next = bpeq_pkg::S_DECODE;
      end
      bpeq_pkg::S_DECODE: begin
        if (stat.put_ok)      state_next = bpeq_pkg::S_SHIFT;
        else if (stat.get_ok) state_next = bpeq_pkg::S_POP;
        else                  state_next = bpeq_pkg::S_FINISH;
      end
      bpeq_pkg::S_SHIFT: begin
        if (!stat.shift_more) state_next = bpeq_pkg::S_FINISH;
      end
      bpeq_pkg::S_POP: begin
        state_next = bpeq_pkg::S_FINISH;
      end
      bpeq_pkg::S_FINISH: begin
        if (stat.out_free) state_next = bpeq_pkg::S_IDLE;
      end
      default: state_next = bpeq_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      bpeq_pkg::S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      bpeq_pkg::S_DECODE: cmd.decode = 1'b1;
      bpeq_pkg::S_SHIFT: begin
        cmd.step  = stat.shift_more;
        cmd.place = !stat.shift_more;
      end
      bpeq_pkg::S_POP:    cmd.capture = 1'b1;
      bpeq_pkg::S_FINISH: cmd.finish  = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ===== sv/bpeq_dp.sv =====
// Datapath: entry store, count, abort flag and result register
`include "bounded_priority_event_queue_defines.svh"

module bpeq_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  bpeq_pkg::dp_cmd_t                   cmd,
  output bpeq_pkg::dp_stat_t                  stat,
  input  logic [bpeq_pkg::OP_W-1:0]           opcode,
  input  logic [bpeq_pkg::HANDLE_W-1:0]       event_handle,
  input  logic signed [bpeq_pkg::PRIO_W-1:0]  priority_req,
  input  logic                                enable,
  input  logic [bpeq_pkg::CNT_W-1:0]          limit,
  input  logic                                rsp_ready,
  output logic                                rsp_valid,
  output logic [2:0]                          status,
  output logic [bpeq_pkg::HANDLE_W-1:0]       event_out,
  output logic [bpeq_pkg::CNT_W-1:0]          entry_count,
  output logic                                is_full,
  output logic                                has_event
);

  // Latched item
  logic [bpeq_pkg::OP_W-1:0]          op_q;
  logic [bpeq_pkg::HANDLE_W-1:0]      handle_q;
  logic signed [bpeq_pkg::PRIO_W-1:0] prio_q;

  // Queue state and working registers
  logic [bpeq_pkg::CNT_W-1:0]    count;
  logic                          abort_flag;
  logic [bpeq_pkg::CNT_W-1:0]    ptr;
  bpeq_pkg::status_t             status_q;
  bpeq_pkg::status_t             status_code;
  logic [bpeq_pkg::HANDLE_W-1:0] popped;

  // RAM ports
  logic                          we;
  logic [bpeq_pkg::ADDR_W-1:0]   waddr;
  logic [bpeq_pkg::ADDR_W-1:0]   raddr;
  logic [bpeq_pkg::ENTRY_W-1:0]  wdata;
  logic [bpeq_pkg::ENTRY_W-1:0]  rdata;
  logic [bpeq_pkg::CNT_W-1:0]    cnt_m1;
  logic [bpeq_pkg::CNT_W-1:0]    ptr_m2;
  logic signed [bpeq_pkg::PRIO_W-1:0] rd_prio;
  logic [bpeq_pkg::HANDLE_W-1:0] rd_handle;

  assign cnt_m1    = count - 1'b1;
  assign ptr_m2    = ptr - 2'd2;
  assign rd_prio   = signed'(rdata[bpeq_pkg::ENTRY_W-1 -: bpeq_pkg::PRIO_W]);
  assign rd_handle = rdata[bpeq_pkg::HANDLE_W-1:0];

  // Checks on the latched item
  always_comb begin
    status_code = bpeq_pkg::ST_OK;
    unique case (op_q)
      bpeq_pkg::OP_PUT: begin
        if (handle_q == '0)     status_code = bpeq_pkg::ST_INVALID;
        else if (!enable)       status_code = bpeq_pkg::ST_UNINIT;
        else if (count >= limit) status_code = bpeq_pkg::ST_FULL;
      end
      bpeq_pkg::OP_GET: begin
        if (!enable)            status_code = bpeq_pkg::ST_UNINIT;
        else if (abort_flag)    status_code = bpeq_pkg::ST_ABORT;
        else if (count == '0)   status_code = bpeq_pkg::ST_EMPTY;
      end
      default: status_code = bpeq_pkg::ST_OK;
    endcase
  end

  assign stat.put_ok     = (op_q == bpeq_pkg::OP_PUT) && (status_code == bpeq_pkg::ST_OK);
  assign stat.get_ok     = (op_q == bpeq_pkg::OP_GET) && (status_code == bpeq_pkg::ST_OK);
  // Entry below ptr moves up while its priority is not lower than the new one
  assign stat.shift_more = (ptr != '0) && (rd_prio >= prio_q);
  assign stat.out_free   = !rsp_valid || rsp_ready;

  // Store access: the walk reads two entries below the one it writes
  assign raddr = cmd.decode ? cnt_m1[bpeq_pkg::ADDR_W-1:0] : ptr_m2[bpeq_pkg::ADDR_W-1:0];
  assign we    = cmd.step || cmd.place;
  assign waddr = ptr[bpeq_pkg::ADDR_W-1:0];
  assign wdata = cmd.step ? rdata : {prio_q, handle_q};

  bpeq_ram #(
    .WIDTH (bpeq_pkg::ENTRY_W),
    .DEPTH (bpeq_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Count and abort flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      abort_flag <= 1'b0;
    end else begin
      if (cmd.decode) begin
        priority if (stat.get_ok) begin
          count <= cnt_m1;
        end else if (op_q == bpeq_pkg::OP_CLEAN) begin
          count <= '0;
        end else if (op_q == bpeq_pkg::OP_ABORT) begin
          abort_flag <= 1'b1;
        end else if (op_q == bpeq_pkg::OP_STOP) begin
          count      <= '0;
          abort_flag <= 1'b0;
        end
      end
      if (cmd.place) begin
        count <= count + 1'b1;
      end
    end
  end

  // Item latch, walk pointer and result fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= opcode;
      handle_q <= event_handle;
      prio_q   <= priority_req;
    end
    if (cmd.decode) begin
      status_q <= status_code;
      popped   <= '0;
      ptr      <= count;
    end
    if (cmd.step) begin
      ptr <= ptr - 1'b1;
    end
    if (cmd.capture) begin
      popped <= rd_handle;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status      <= status_q;
      event_out   <= popped;
      entry_count <= count;
      is_full     <= (count >= limit);
      has_event   <= (count != '0);
    end
  end

  `BPEQ_ASSERT(a_count_bound, count <= bpeq_pkg::CNT_DEPTH, "entry count above depth")
  `BPEQ_ASSERT(a_ptr_bound, !(cmd.step || cmd.place) || (ptr <= count), "walk pointer past count")
  `BPEQ_ASSERT(a_put_room, !cmd.place || (count < limit), "insert into a full queue")
  `BPEQ_ASSERT_NEXT(a_place_grows, cmd.place, count == $past(count) + 1'b1, "insert lost count")

endmodule

// ===== sv/bounded_priority_event_queue.sv =====
// Top level of the bounded priority event queue: register port and block wiring
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------------
//  request   | req_valid / req_ready      | opcode, event_handle, priority_req
//  response  | rsp_valid / rsp_ready      | status, event_out, entry_count, is_full,
//            |                            | has_event
//  registers | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
//  Each item takes count-independent time except an accepted put, whose walk moves up m
//  entries (0 to 63), one entry per store cycle; a get passes through decode, pop and
//  finish, anything else through decode and finish.
//  Reset (synchronous, rst high) empties the queue, clears the abort flag, disables the
//  queue and sets max_entries to 64; the entry store itself is not cleared.
//  A held result waits in the output register; the request side stays open meanwhile,
//  and the sequencer stalls only at its final step until that register is free.
module bounded_priority_event_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bpeq_pkg::PADDR_W-1:0]        paddr,
  input  logic [bpeq_pkg::PDATA_W-1:0]        pwdata,
  output logic [bpeq_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [bpeq_pkg::OP_W-1:0]           opcode,
  input  logic [bpeq_pkg::HANDLE_W-1:0]       event_handle,
  input  logic signed [bpeq_pkg::PRIO_W-1:0]  priority_req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic [2:0]                          status,
  output logic [bpeq_pkg::HANDLE_W-1:0]       event_out,
  output logic [bpeq_pkg::CNT_W-1:0]          entry_count,
  output logic                                is_full,
  output logic                                has_event
);

  logic                          enable;
  logic [bpeq_pkg::MAXE_W-1:0]   max_entries;
  logic [bpeq_pkg::CNT_W-1:0]    limit;
  bpeq_pkg::dp_cmd_t             cmd;
  bpeq_pkg::dp_stat_t            stat;

  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      max_entries <= bpeq_pkg::MAXE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        bpeq_pkg::REG_ENABLE: enable      <= pwdata[0];
        bpeq_pkg::REG_MAX:    max_entries <= pwdata[bpeq_pkg::MAXE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[2])
      bpeq_pkg::REG_ENABLE: prdata = bpeq_pkg::PDATA_W'(enable);
      bpeq_pkg::REG_MAX:    prdata = bpeq_pkg::PDATA_W'(max_entries);
      default:              prdata = '0;
    endcase
  end

  // Effective limit: the smaller of max_entries and the store depth
  always_comb begin
    if (int'(max_entries) > bpeq_pkg::DEPTH) begin
      limit = bpeq_pkg::CNT_DEPTH;
    end else begin
      limit = bpeq_pkg::CNT_W'(max_entries);
    end
  end

  bpeq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpeq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (opcode),
    .event_handle (event_handle),
    .priority_req (priority_req),
    .enable       (enable),
    .limit        (limit),
    .rsp_ready    (rsp_ready),
    .rsp_valid    (rsp_valid),
    .status       (status),
    .event_out    (event_out),
    .entry_count  (entry_count),
    .is_full      (is_full),
    .has_event    (has_event)
  );

endmodule
